// ----- hw/rtl/fmpacl_pkg.sv -----
// Shared types, codes and defaults for the first-match port access list.
package fmpacl_pkg;

    // Default number of rule slots
    localparam int MAX_RULES_DEF = 16;

    localparam int OP_W     = 2;
    localparam int PORT_W   = 16;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_APPEND = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_RULE = 2'd2;

    // One stored rule, 34 bits
    typedef struct packed {
        logic              accept;
        logic [PORT_W-1:0] port_lo;
        logic [PORT_W-1:0] port_hi;
        logic              specific;
    } t_rule;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/first_match_port_acl.sv -----
// Check: walks the stored rules in order and stops at the first hit.
// Remove at P moves each later rule up one slot; append and the unused op go straight to the result state.
// One rule is read from the rule memory and compared per cycle through a single comparator.
// One item at a time: o_ready is high only while the sequencer is idle.
// Synchronous active-low reset clears the rule count, sequencer and output valid;
// rule memory contents are not cleared.
module first_match_port_acl #(
    parameter int MAX_RULES = fmpacl_pkg::MAX_RULES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [fmpacl_pkg::OP_W-1:0]     i_operation,
    input  logic [fmpacl_pkg::PORT_W-1:0]   i_port,
    input  logic                            i_rule_accept,
    input  logic [fmpacl_pkg::PORT_W-1:0]   i_rule_start,
    input  logic [fmpacl_pkg::PORT_W-1:0]   i_rule_end,
    input  logic                            i_rule_specific_address,
    input  logic [fmpacl_pkg::POS_W-1:0]    i_rule_position,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_allowed,
    output logic [fmpacl_pkg::STATUS_W-1:0] o_status
);

    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int PW = (CW > fmpacl_pkg::POS_W) ? CW : fmpacl_pkg::POS_W;

    fmpacl_pkg::t_state r_state, n_state;
    fmpacl_pkg::t_rule  r_mem [MAX_RULES];
    fmpacl_pkg::t_rule  r_rd;

    logic [CW-1:0]                   r_count, n_count;
    logic [CW-1:0]                   r_idx, n_idx;
    logic                            r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]                   r_wr_addr, n_wr_addr;
    logic [fmpacl_pkg::PORT_W-1:0]   r_port, n_port;
    logic                            r_allowed, n_allowed;
    logic [fmpacl_pkg::STATUS_W-1:0] r_status, n_status;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_allowed, n_out_allowed;
    logic [fmpacl_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    logic              in_acc;
    logic              out_free;
    logic              issue;
    logic              hit;
    logic              full;
    logic              pos_ok;
    logic [PW-1:0]     pos_ext;
    logic [CW-1:0]     idx_m1;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    fmpacl_pkg::t_rule mem_wd;
    fmpacl_pkg::t_op   op;

    assign op       = fmpacl_pkg::t_op'(i_operation);
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign issue    = r_idx < r_count;
    assign full     = r_count >= CW'(MAX_RULES);
    assign pos_ext  = PW'(i_rule_position);
    assign pos_ok   = pos_ext < PW'(r_count);
    assign idx_m1   = r_idx - CW'(1);

    // Shared rule comparator on the registered memory read
    always_comb begin
        if (r_rd.specific) begin
            hit = 1'b0;
        end else if (r_rd.port_hi == '0) begin
            hit = (r_rd.port_lo == '0) || (r_rd.port_lo == r_port);
        end else begin
            hit = (r_port >= r_rd.port_lo) && (r_port <= r_rd.port_hi);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fmpacl_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (op)
                        fmpacl_pkg::OP_CHECK:  n_state = fmpacl_pkg::S_CHECK;
                        fmpacl_pkg::OP_REMOVE: n_state = pos_ok ? fmpacl_pkg::S_SHIFT
                                                                : fmpacl_pkg::S_DONE;
                        default:               n_state = fmpacl_pkg::S_DONE;
                    endcase
                end
            end
            fmpacl_pkg::S_CHECK: begin
                if ((r_cmp_vld && hit) || !issue) begin
                    n_state = fmpacl_pkg::S_DONE;
                end
            end
            fmpacl_pkg::S_SHIFT: begin
                if (!issue) begin
                    n_state = fmpacl_pkg::S_DONE;
                end
            end
            fmpacl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = fmpacl_pkg::S_IDLE;
                end
            end
            default: n_state = fmpacl_pkg::S_IDLE;
        endcase
    end

    // Datapath control and outputs
    always_comb begin
        n_count       = r_count;
        n_idx         = r_idx;
        n_cmp_vld     = 1'b0;
        n_wr_addr     = idx_m1[AW-1:0];
        n_port        = r_port;
        n_allowed     = r_allowed;
        n_status      = r_status;
        n_out_valid   = r_out_valid && !i_ready;
        n_out_allowed = r_out_allowed;
        n_out_status  = r_out_status;
        mem_we        = 1'b0;
        mem_wa        = r_count[AW-1:0];
        mem_wd        = '{accept:   i_rule_accept,
                          port_lo:  i_rule_start,
                          port_hi:  i_rule_end,
                          specific: i_rule_specific_address};
        case (r_state)
            fmpacl_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_allowed = 1'b0;
                    n_status  = fmpacl_pkg::ST_OK;
                    case (op)
                        fmpacl_pkg::OP_CHECK: begin
                            n_idx     = '0;
                            n_port    = i_port;
                            n_allowed = 1'b1;
                        end
                        fmpacl_pkg::OP_APPEND: begin
                            if (full) begin
                                n_status = fmpacl_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        fmpacl_pkg::OP_REMOVE: begin
                            if (pos_ok) begin
                                n_idx = CW'(pos_ext + PW'(1));
                            end else begin
                                n_status = fmpacl_pkg::ST_NO_RULE;
                            end
                        end
                        default: begin
                            n_status = fmpacl_pkg::ST_OK;
                        end
                    endcase
                end
            end
            // Walk rules in order; stop at the first hit
            fmpacl_pkg::S_CHECK: begin
                n_cmp_vld = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_cmp_vld && hit) begin
                    n_allowed = r_rd.accept;
                    n_cmp_vld = 1'b0;
                end
            end
            // Move each later rule up by one slot
            fmpacl_pkg::S_SHIFT: begin
                n_cmp_vld = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                end
                if (r_cmp_vld) begin
                    mem_we = 1'b1;
                    mem_wa = r_wr_addr;
                    mem_wd = r_rd;
                end
            end
            fmpacl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_allowed = r_allowed;
                    n_out_status  = r_status;
                end
            end
            default: begin
                n_cmp_vld = 1'b0;
            end
        endcase
    end

    // Rule memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[r_idx[AW-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fmpacl_pkg::S_IDLE;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_wr_addr     <= n_wr_addr;
        r_port        <= n_port;
        r_allowed     <= n_allowed;
        r_status      <= n_status;
        r_out_allowed <= n_out_allowed;
        r_out_status  <= n_out_status;
    end

    assign o_ready   = (r_state == fmpacl_pkg::S_IDLE);
    assign o_valid   = r_out_valid;
    assign o_allowed = r_out_allowed;
    assign o_status  = r_out_status;

    // Rule count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RULES))
        else $error("rule count exceeds table depth");

    // Rule count moves by at most one per cycle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) || r_count + CW'(1) == $past(r_count)))
        else $error("rule count jumped");

    // An accepted item leaves the idle state
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != fmpacl_pkg::S_IDLE))
        else $error("sequencer stayed idle after accept");

    // Count changes only while appending or finishing a shift
    a_count_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == fmpacl_pkg::S_IDLE || $past(r_state) == fmpacl_pkg::S_SHIFT))
        else $error("rule count changed outside append or remove");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the first-match port access list.
module tb_top;
    import fmpacl_pkg::*;

    localparam int RULE_SLOTS      = MAX_RULES_DEF;
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int LOG_CAP         = 30;

    typedef struct packed {
        logic                allowed;
        logic [STATUS_W-1:0] status;
    } t_verdict;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_operation;
    logic [PORT_W-1:0]   i_port;
    logic                i_rule_accept;
    logic [PORT_W-1:0]   i_rule_start;
    logic [PORT_W-1:0]   i_rule_end;
    logic                i_rule_specific_address;
    logic [POS_W-1:0]    i_rule_position;
    logic                o_valid;
    logic                i_ready;
    logic                o_allowed;
    logic [STATUS_W-1:0] o_status;

    // Shadow copy of the rule list
    t_rule    acl_rules [RULE_SLOTS];
    int       n_rules = 0;
    t_verdict pending_verdicts [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int hold_cycles    = 0;
    bit no_idle        = 1'b0;

    // Free-running clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    first_match_port_acl #(
        .MAX_RULES(RULE_SLOTS)
    ) i_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_operation            (i_operation),
        .i_port                 (i_port),
        .i_rule_accept          (i_rule_accept),
        .i_rule_start           (i_rule_start),
        .i_rule_end             (i_rule_end),
        .i_rule_specific_address(i_rule_specific_address),
        .i_rule_position        (i_rule_position),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_allowed              (o_allowed),
        .o_status               (o_status)
    );

    // A flagged rule never hits; end 0 means any port (start 0) or one port
    function automatic bit rule_hits(input t_rule r, input logic [PORT_W-1:0] port);
        if (r.specific)
            return 1'b0;
        if (r.port_hi == '0)
            return (r.port_lo == '0) || (r.port_lo == port);
        return (port >= r.port_lo) && (port <= r.port_hi);
    endfunction

    // Apply one operation to the shadow list and return its verdict
    function automatic t_verdict apply_acl_op(input t_op op, input logic [PORT_W-1:0] port,
                                              input t_rule rule, input logic [POS_W-1:0] pos);
        t_verdict v;
        bit       hit;
        v.allowed = 1'b0;
        v.status  = ST_OK;
        hit       = 1'b0;
        case (op)
            OP_CHECK: begin
                v.allowed = 1'b1;
                for (int k = 0; k < n_rules; k++) begin
                    if (!hit && rule_hits(acl_rules[k], port)) begin
                        hit       = 1'b1;
                        v.allowed = acl_rules[k].accept;
                    end
                end
            end
            OP_APPEND: begin
                if (n_rules >= RULE_SLOTS) begin
                    v.status = ST_FULL;
                end else begin
                    acl_rules[n_rules] = rule;
                    n_rules++;
                end
            end
            OP_REMOVE: begin
                if (pos >= n_rules) begin
                    v.status = ST_NO_RULE;
                end else begin
                    for (int k = pos; k < n_rules - 1; k++)
                        acl_rules[k] = acl_rules[k + 1];
                    n_rules--;
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // Bias ports toward the small window the rules live in and toward rule edges
    function automatic logic [PORT_W-1:0] draw_port();
        t_rule r;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 16'($urandom_range(0, 63));
            4: begin
                if (n_rules == 0)
                    return 16'($urandom);
                r = acl_rules[$urandom_range(0, n_rules - 1)];
                case ($urandom_range(0, 3))
                    0:       return r.port_lo;
                    1:       return r.port_hi;
                    2:       return r.port_lo - 1'b1;
                    default: return r.port_hi + 1'b1;
                endcase
            end
            5: begin
                if ($urandom_range(0, 1))
                    return 16'($urandom_range(0, 1));
                return 16'hFFFF - 16'($urandom_range(0, 1));
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // Mix match-all, single-port, narrow, wide and inverted ranges
    function automatic t_rule draw_rule();
        t_rule r;
        r.accept   = 1'($urandom);
        r.specific = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 4))
            0, 1, 2: r.port_lo = 16'($urandom_range(0, 63));
            3:       r.port_lo = 16'($urandom);
            default: r.port_lo = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        case ($urandom_range(0, 7))
            0, 1:       r.port_hi = '0;
            2, 3, 4, 5: r.port_hi = (r.port_lo > 16'hFFEF) ? 16'hFFFF
                                    : r.port_lo + 16'($urandom_range(0, 16));
            6:          r.port_hi = 16'($urandom);
            default:    r.port_hi = 16'hFFFF;
        endcase
        return r;
    endfunction

    // Mostly a live position, sometimes any position
    function automatic logic [POS_W-1:0] draw_position();
        logic [POS_W-1:0] p;
        if (n_rules > 0 && $urandom_range(0, 6) != 0)
            p = POS_W'($urandom_range(0, n_rules - 1));
        else
            p = POS_W'($urandom);
        return p;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        // cap the log, keep counting
        if (mismatch_count <= LOG_CAP)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input t_op op, input logic [PORT_W-1:0] port,
                             input t_rule rule, input logic [POS_W-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid      = 1'b0;
            i_port       = 16'($urandom);
            i_rule_start = 16'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_operation             = op;
        i_port                  = port;
        i_rule_accept           = rule.accept;
        i_rule_start            = rule.port_lo;
        i_rule_end              = rule.port_hi;
        i_rule_specific_address = rule.specific;
        i_rule_position         = pos;
        i_valid                 = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_verdicts.push_back(apply_acl_op(op, port, rule, pos));
    endtask

    task automatic send_check(input logic [PORT_W-1:0] port);
        send_item(OP_CHECK, port, draw_rule(), 4'($urandom));
    endtask

    task automatic send_append(input logic acc, input logic [PORT_W-1:0] lo,
                               input logic [PORT_W-1:0] hi, input logic spec);
        t_rule r;
        r.accept   = acc;
        r.port_lo  = lo;
        r.port_hi  = hi;
        r.specific = spec;
        send_item(OP_APPEND, draw_port(), r, 4'($urandom));
    endtask

    task automatic send_remove(input logic [POS_W-1:0] pos);
        send_item(OP_REMOVE, draw_port(), draw_rule(), pos);
    endtask

    task automatic run_random_traffic(input int n_items, input int append_pct,
                                      input int remove_pct);
        int pick;
        t_op op;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < append_pct)
                op = OP_APPEND;
            else if (pick < append_pct + remove_pct)
                op = OP_REMOVE;
            else if (pick >= 96)
                op = OP_NONE;
            else
                op = OP_CHECK;
            send_item(op, draw_port(), draw_rule(), draw_position());
        end
    endtask

    // Empty table: everything allowed, remove finds nothing, unused code is inert
    task automatic test_empty_table();
        send_check(16'h0000);
        send_check(16'hFFFF);
        send_remove(4'd0);
        send_item(OP_NONE, draw_port(), draw_rule(), draw_position());
    endtask

    // First hit wins; flagged rules are skipped; port zero hits a range from zero
    task automatic test_first_match_order();
        send_append(1'b0, 16'd0, 16'd0, 1'b1);
        send_append(1'b0, 16'd80, 16'd0, 1'b0);
        send_append(1'b1, 16'd0, 16'd100, 1'b0);
        send_append(1'b0, 16'd0, 16'd0, 1'b0);
        send_check(16'd80);
        send_check(16'd0);
        send_check(16'd100);
        send_check(16'd101);
        send_check(16'hFFFF);
        send_remove(4'd1);
        send_check(16'd80);
    endtask

    // Fill to the top, overflow, then remove at the last and first slots
    task automatic test_full_table();
        int k;
        k = 0;
        send_remove(4'd2);
        while (n_rules < RULE_SLOTS) begin
            if (n_rules == RULE_SLOTS - 1)
                send_append(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
            else
                send_append(k[0], 16'(40000 + 100 * k), 16'(40050 + 100 * k), 1'b0);
            k++;
        end
        send_append(1'b1, 16'd0, 16'd0, 1'b0);
        send_check(16'hFFFF);
        send_remove(4'd15);
        send_remove(4'd15);
        send_remove(4'd0);
    endtask

    // Balanced, remove-heavy and append-heavy mixes
    task automatic test_random_traffic();
        run_random_traffic(500, 30, 20);
        run_random_traffic(400, 20, 35);
        run_random_traffic(400, 45, 10);
    endtask

    // No gaps on either side
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_random_traffic(400, 30, 20);
        no_idle = 1'b0;
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_output_stall();
        hold_cycles = HOLD_OFF_CYCLES;
        run_random_traffic(60, 30, 20);
    endtask

    // Receiver: random stall per result, plus the long hold-off on request
    initial begin
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each result with the oldest pending verdict
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result allowed=%0d status=%0d",
                                          o_allowed, o_status));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_allowed !== want.allowed)
                    report_mismatch($sformatf("allowed: got %0d, want %0d",
                                              o_allowed, want.allowed));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status: got %0d, want %0d",
                                              o_status, want.status));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("first_match_port_acl: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n                 = 1'b0;
        i_valid                 = 1'b0;
        i_operation             = OP_CHECK;
        i_port                  = '0;
        i_rule_accept           = 1'b0;
        i_rule_start            = '0;
        i_rule_end              = '0;
        i_rule_specific_address = 1'b0;
        i_rule_position         = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_first_match_order();
        test_full_table();
        test_random_traffic();
        test_back_to_back();
        test_output_stall();

        // Drop valid, drain, then watch for stray results
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("first_match_port_acl: match");
        else
            $display("first_match_port_acl: mismatch");
        $finish;
    end

endmodule
